@@ hw/rtl/vertex_index_dedup_defines.svh @@
// Assertion macros used by the checker file of the vertex dedup block.
`ifndef VERTEX_INDEX_DEDUP_DEFINES_SVH
`define VERTEX_INDEX_DEDUP_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define VID_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define VID_ASSERT_SAME(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define VID_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ hw/rtl/vid_pkg.sv @@
// Shared types and defaults of the vertex index dedup block.
`default_nettype none
package vid_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int INDEX_BITS_DEF  = 16;
  // Width of one index field on the stream ports
  localparam int IDX_FIELD_W     = 16;
  localparam int VNUM_FIELD_W    = 8;
  localparam int COUNT_FIELD_W   = 9;

  // Control part of the lookup token that walks the cell row
  typedef struct packed {
    logic active;    // token present in this stage
    logic hit;       // matched a stored triple
    logic appended;  // written into a free entry
  } tok_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/vid_cell.sv @@
// One table cell: holds one triple and forwards the lookup token to its neighbor.
`default_nettype none
module vid_cell #(
  parameter int DEPTH    = vid_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_W    = 3 * vid_pkg::INDEX_BITS_DEF,
  parameter int CELL_IDX = 0,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int VN_W    = $clog2(DEPTH)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [CNT_W-1:0]      count,
  input  vid_pkg::tok_ctl_t    ctl_in,
  input  wire [KEY_W-1:0]      key_in,
  input  wire [VN_W-1:0]       vnum_in,
  output vid_pkg::tok_ctl_t    ctl_out,
  output logic [KEY_W-1:0]     key_out,
  output logic [VN_W-1:0]      vnum_out
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(CELL_IDX);
  localparam logic [VN_W-1:0]  MY_VNUM = VN_W'(CELL_IDX);

  logic [KEY_W-1:0]   entry_r;
  vid_pkg::tok_ctl_t  ctl_r, ctl_nxt;
  logic [KEY_W-1:0]   key_r;
  logic [VN_W-1:0]    vnum_r, vnum_nxt;
  logic               undecided;
  logic               match;
  logic               append;

  always_comb begin
    undecided = ctl_in.active && !ctl_in.hit && !ctl_in.appended;
    match     = undecided && (MY_IDX < count) && (entry_r == key_in);
    // The first free entry sits exactly at the fill count
    append    = undecided && (MY_IDX == count);
    ctl_nxt          = ctl_in;
    ctl_nxt.hit      = ctl_in.hit || match;
    ctl_nxt.appended = ctl_in.appended || append;
    vnum_nxt         = (match || append) ? MY_VNUM : vnum_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_in;
    vnum_r <= vnum_nxt;
    if (append) begin
      entry_r <= key_in;
    end
  end

  assign ctl_out  = ctl_r;
  assign key_out  = key_r;
  assign vnum_out = vnum_r;

endmodule
`default_nettype wire

@@ hw/rtl/vertex_index_dedup.sv @@
// Top level of the vertex index dedup block: cell row, fill count and stream ports.
//
// Vertex deduplication for indexed meshes. Each input transfer carries one face
// corner (position, texture and normal index); the block answers with the vertex
// number of that triple, appending unseen triples to a table of TABLE_DEPTH
// entries held in a row of cells. first_corner empties the table before the
// corner is looked up. When an unseen triple finds the table full, the result
// has table_full set, vertex_number 0 and the count unchanged; stored triples
// still match. On its way to the result, a corner's lookup token is launched into
// a register at the transfer edge, walks the cell row one cell per clock and is
// captured in the output register. One corner is in flight at a time; the next
// input transfer is taken once that result sits in the output register and is
// being or has been transferred. No clearing pass is needed after reset: only
// entries below the fill count are ever compared.
`default_nettype none
module vertex_index_dedup #(
  parameter int TABLE_DEPTH = vid_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_BITS  = vid_pkg::INDEX_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // Corner input
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [47:0]  in_tdata,   // position_index[15:0], texcoord_index[31:16],
                                  // normal_index[47:32]
  input  wire [0:0]   in_tuser,   // first_corner[0]
  // Result output
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // vertex_number[7:0], unique_count[16:8], zero[23:17]
  output logic [1:0]  out_tuser   // is_new[0], table_full[1]
);

  localparam int FW    = vid_pkg::IDX_FIELD_W;
  // Indices are compared in their low INDEX_BITS bits, at most the field width
  localparam int KB    = (INDEX_BITS < FW) ? INDEX_BITS : FW;
  localparam int KEY_W = 3 * KB;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int VN_W  = $clog2(TABLE_DEPTH);
  localparam int VNF_W = vid_pkg::VNUM_FIELD_W;
  localparam int CNF_W = vid_pkg::COUNT_FIELD_W;

  // Token chain between cells; stage 0 is the launch register
  vid_pkg::tok_ctl_t  ctl_chain  [0:TABLE_DEPTH];
  logic [KEY_W-1:0]   key_chain  [0:TABLE_DEPTH];
  logic [VN_W-1:0]    vnum_chain [0:TABLE_DEPTH];

  vid_pkg::tok_ctl_t  launch_ctl_r, launch_ctl_nxt;
  logic [KEY_W-1:0]   launch_key_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VNF_W-1:0]   out_vnum_r;
  logic [CNF_W-1:0]   out_count_r;
  logic               out_new_r;
  logic               out_full_r;

  logic               in_fire;
  logic               done;
  vid_pkg::tok_ctl_t  end_ctl;
  logic [KEY_W-1:0]   key_in;
  logic [VN_W+VNF_W-1:0] vnum_ext;
  logic [CNT_W+CNF_W-1:0] count_ext;

  // Take the next corner only when idle and the output register will be free
  assign in_tready = !busy_r && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign key_in    = {in_tdata[32 +: KB], in_tdata[16 +: KB], in_tdata[0 +: KB]};

  assign end_ctl = ctl_chain[TABLE_DEPTH];
  assign done    = end_ctl.active;

  assign ctl_chain[0]  = launch_ctl_r;
  assign key_chain[0]  = launch_key_r;
  assign vnum_chain[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      vid_cell #(
        .DEPTH    (TABLE_DEPTH),
        .KEY_W    (KEY_W),
        .CELL_IDX (gi)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .count    (count_r),
        .ctl_in   (ctl_chain[gi]),
        .key_in   (key_chain[gi]),
        .vnum_in  (vnum_chain[gi]),
        .ctl_out  (ctl_chain[gi+1]),
        .key_out  (key_chain[gi+1]),
        .vnum_out (vnum_chain[gi+1])
      );
    end
  endgenerate

  always_comb begin
    launch_ctl_nxt          = '0;
    launch_ctl_nxt.active   = in_fire;
    busy_nxt                = busy_r;
    count_nxt               = count_r;
    out_valid_nxt           = out_valid_r && !out_tready;
    if (in_fire) begin
      busy_nxt = 1'b1;
      // Empty the table before this corner is looked up
      if (in_tuser[0]) begin
        count_nxt = '0;
      end
    end
    if (done) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      count_nxt     = count_r + CNT_W'(end_ctl.appended);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_ctl_r <= '0;
      count_r      <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      launch_ctl_r <= launch_ctl_nxt;
      count_r      <= count_nxt;
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Mask the vertex number and count to their field widths
  assign vnum_ext  = {{VNF_W{1'b0}}, vnum_chain[TABLE_DEPTH]};
  assign count_ext = {{CNF_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      launch_key_r <= key_in;
    end
    if (done) begin
      out_vnum_r  <= vnum_ext[VNF_W-1:0];
      out_count_r <= count_ext[CNF_W-1:0];
      out_new_r   <= end_ctl.appended;
      out_full_r  <= !end_ctl.hit && !end_ctl.appended;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_count_r, out_vnum_r};
  assign out_tuser  = {out_full_r, out_new_r};

endmodule
`default_nettype wire

@@ hw/rtl/vid_checker.sv @@
// Port-level assertions for the vertex index dedup block, bound to its top level.
`default_nettype none
`include "vertex_index_dedup_defines.svh"
module vid_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [47:0] in_tdata,
  input wire [0:0]  in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire [1:0]  out_tuser
);

  logic unused_in;
  assign unused_in = ^{in_tdata, in_tuser};

  // A stalled result holds until transferred
  `VID_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  // One corner at a time: no input transfer right after one
  `VID_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second corner taken while busy")
  // A corner may be new, rejected or neither, but never both
  `VID_ASSERT_SAME(a_new_xor_full, out_tvalid, !(out_tuser[0] && out_tuser[1]), "new and full both set")
  // A rejected corner reports vertex number zero
  `VID_ASSERT_SAME(a_full_vnum, out_tvalid && out_tuser[1], out_tdata[7:0] == 8'd0, "full result with nonzero vertex")
  // Padding bits stay clear
  `VID_ASSERT_ALWAYS(a_pad_zero, out_tdata[23:17] == 7'd0, "tdata padding not zero")

endmodule

bind vertex_index_dedup vid_checker u_vid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
